// ===== sv/pktdfr_pkg.sv =====
// Shared constants, result codes and a tail-byte helper for the packet deframer.
package pktdfr_pkg;

	localparam logic [7:0] HDR_B0  = 8'hDD;
	localparam logic [7:0] HDR_B1  = 8'hBB;
	localparam logic [7:0] HDR_B2  = 8'hAA;
	localparam logic [7:0] TAIL_B0 = 8'hEE;
	localparam logic [7:0] TAIL_B1 = 8'hBB;
	localparam logic [7:0] TAIL_B2 = 8'hAA;

	localparam int          MAX_LEN_W     = 24;
	localparam logic [23:0] MAX_LEN_RESET = 24'd65535;
	localparam int          PADDR_W       = 3;

	// APB register offsets
	localparam logic [PADDR_W-1:0] REG_MAX_LEN = 3'd0;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_ACCEPT   = 2'd1,
		KIND_BAD_TAIL = 2'd2,
		KIND_TOO_LONG = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [31:0] packet_index;
		logic [15:0] packet_type;
		logic [31:0] payload_length;
	} result_t;

	function automatic logic [7:0] tail_byte(input logic [1:0] pos);
		logic [7:0] r;
		case (pos)
			2'd0:    r = TAIL_B0;
			2'd1:    r = TAIL_B1;
			default: r = TAIL_B2;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/packet_deframer_unit.sv =====
// Packet deframer: header hunt, field capture, payload pass-through and tail check.
// A result is registered into the output register, or into the skid when the output is held, as its byte is accepted.
// One byte per cycle while in_stall is low; the header/field/tail state update is a single step.
// A two-entry output (register plus skid) holds results; in_stall rises only when the skid is full.
// Reset (arst_n, async low): hunting, recent bytes cleared, output empty, max length 65535.
module packet_deframer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         in_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         kind,
	output logic [7:0]                         payload_byte,
	output logic [31:0]                        packet_index,
	output logic [15:0]                        packet_type,
	output logic [31:0]                        payload_length,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pktdfr_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_INDEX   = 3'd1,
		PH_TYPE    = 3'd2,
		PH_LENGTH  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_TAIL    = 3'd5
	} phase_t;

	phase_t                                phase_q, phase_n;
	logic [1:0]                            cnt_q, cnt_n;
	logic [15:0]                           recent_q, recent_n;
	logic [31:0]                           index_q, index_n;
	logic [15:0]                           type_q, type_n;
	logic [31:0]                           length_q, length_n;
	logic [31:0]                           left_q, left_n;
	logic [pktdfr_pkg::MAX_LEN_W-1:0]      max_len_q;

	logic                                  has_res;
	pktdfr_pkg::kind_t                     res_kind;
	logic [7:0]                            res_byte;
	pktdfr_pkg::result_t                   res_new, out_q, skid_q;
	logic                                  out_v_q, skid_v_q;
	logic                                  in_acc, out_take, cfg_wr;
	logic [4:0]                            sh;

	assign in_stall = skid_v_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_v_q && !out_stall;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == pktdfr_pkg::REG_MAX_LEN) ?
		{{(32 - pktdfr_pkg::MAX_LEN_W){1'b0}}, max_len_q} : 32'd0;

	assign sh = {cnt_q, 3'b000};

	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		recent_n = recent_q;
		index_n  = index_q;
		type_n   = type_q;
		length_n = length_q;
		left_n   = left_q;
		has_res  = 1'b0;
		res_kind = pktdfr_pkg::KIND_PAYLOAD;
		res_byte = 8'd0;
		unique case (phase_q)
			PH_INDEX: begin
				index_n = index_q | ({24'd0, in_byte} << sh);
				cnt_n   = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					phase_n = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_n = type_q | ({8'd0, in_byte} << {cnt_q[0], 3'b000});
				if (cnt_q != 2'd0) begin
					cnt_n   = 2'd0;
					phase_n = PH_LENGTH;
				end else begin
					cnt_n = 2'd1;
				end
			end
			PH_LENGTH: begin
				length_n = length_q | ({24'd0, in_byte} << sh);
				cnt_n    = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					if (length_n > {{(32 - pktdfr_pkg::MAX_LEN_W){1'b0}}, max_len_q}) begin
						phase_n  = PH_HUNT;
						recent_n = 16'd0;
						has_res  = 1'b1;
						res_kind = pktdfr_pkg::KIND_TOO_LONG;
					end else begin
						left_n  = length_n;
						phase_n = (length_n == 32'd0) ? PH_TAIL : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				has_res  = 1'b1;
				res_kind = pktdfr_pkg::KIND_PAYLOAD;
				res_byte = in_byte;
				left_n   = left_q - 32'd1;
				if (left_q == 32'd1) begin
					cnt_n   = 2'd0;
					phase_n = PH_TAIL;
				end
			end
			PH_TAIL: begin
				if (cnt_q == 2'd3 || in_byte != pktdfr_pkg::tail_byte(cnt_q)) begin
					// bad tail byte may start the next header
					phase_n  = PH_HUNT;
					cnt_n    = 2'd0;
					recent_n = {8'd0, in_byte};
					has_res  = 1'b1;
					res_kind = pktdfr_pkg::KIND_BAD_TAIL;
				end else if (cnt_q == 2'd2) begin
					phase_n  = PH_HUNT;
					cnt_n    = 2'd0;
					recent_n = 16'd0;
					has_res  = 1'b1;
					res_kind = pktdfr_pkg::KIND_ACCEPT;
				end else begin
					cnt_n = cnt_q + 2'd1;
				end
			end
			default: begin
				if (recent_q == {pktdfr_pkg::HDR_B0, pktdfr_pkg::HDR_B1} &&
				    in_byte == pktdfr_pkg::HDR_B2) begin
					phase_n  = PH_INDEX;
					cnt_n    = 2'd0;
					recent_n = 16'd0;
					index_n  = 32'd0;
					type_n   = 16'd0;
					length_n = 32'd0;
					left_n   = 32'd0;
				end else begin
					phase_n  = PH_HUNT;
					recent_n = {recent_q[7:0], in_byte};
				end
			end
		endcase
	end

	assign res_new = '{kind: res_kind, payload_byte: res_byte, packet_index: index_n,
		packet_type: type_n, payload_length: length_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			cnt_q     <= 2'd0;
			recent_q  <= 16'd0;
			index_q   <= 32'd0;
			type_q    <= 16'd0;
			length_q  <= 32'd0;
			left_q    <= 32'd0;
			max_len_q <= pktdfr_pkg::MAX_LEN_RESET;
		end else begin
			if (cfg_wr && paddr == pktdfr_pkg::REG_MAX_LEN) begin
				max_len_q <= pwdata[pktdfr_pkg::MAX_LEN_W-1:0];
			end
			if (in_acc) begin
				phase_q  <= phase_n;
				cnt_q    <= cnt_n;
				recent_q <= recent_n;
				index_q  <= index_n;
				type_q   <= type_n;
				length_q <= length_n;
				left_q   <= left_n;
			end
		end
	end

	// output register plus skid; skid is empty whenever a transaction is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (in_acc && has_res) begin
			if (!out_v_q || out_take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_take) begin
			out_v_q  <= skid_v_q;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_res) begin
			if (!out_v_q || out_take) begin
				out_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end else if (out_take && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid      = out_v_q;
	assign kind           = out_q.kind;
	assign payload_byte   = out_q.payload_byte;
	assign packet_index   = out_q.packet_index;
	assign packet_type    = out_q.packet_type;
	assign payload_length = out_q.payload_length;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a result while output register is empty");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.kind != pktdfr_pkg::KIND_PAYLOAD) |-> out_q.payload_byte == 8'd0)
		else $error("nonzero payload byte on a status result");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> left_q != 32'd0)
		else $error("payload phase with no bytes left");

	a_tail_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TAIL) |-> cnt_q != 2'd3)
		else $error("tail position out of range");

endmodule

// ===== dv/tb_packet_deframer_unit.sv =====
// Self-checking testbench for packet_deframer_unit: byte stream driver, result monitor, predictor.
`timescale 1ns / 1ps

module tb_packet_deframer_unit;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BYTES = 185;

	typedef enum logic [2:0] {
		SEEK_HEADER,
		READ_INDEX,
		READ_TYPE,
		READ_LENGTH,
		PASS_PAYLOAD,
		CHECK_TAIL
	} deframe_phase_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [7:0]                      in_byte = 8'h00;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [1:0]                      kind;
	logic [7:0]                      payload_byte;
	logic [31:0]                     packet_index;
	logic [15:0]                     packet_type;
	logic [31:0]                     payload_length;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [pktdfr_pkg::PADDR_W-1:0]  paddr = '0;
	logic [31:0]                     pwdata = 32'h0;
	logic [31:0]                     prdata;
	logic                            pready;

	packet_deframer_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.packet_index   (packet_index),
		.packet_type    (packet_type),
		.payload_length (payload_length),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// stimulus and expected traffic
	logic [7:0]          pending_bytes [$];
	pktdfr_pkg::result_t expected_results [$];
	int                  bytes_made = 0;
	int                  error_count = 0;
	int                  cycle_count = 0;
	int                  send_idle_pct = 20;
	int                  recv_idle_pct = 70;
	logic                start_long_hold = 1'b0;
	logic                long_hold_done = 1'b0;
	int                  hold_left = 0;

	// predictor state
	deframe_phase_t trk_phase = SEEK_HEADER;
	logic [1:0]     trk_cnt = 2'd0;
	logic [15:0]    trk_recent = 16'h0;
	logic [31:0]    trk_index = 32'h0;
	logic [15:0]    trk_type = 16'h0;
	logic [31:0]    trk_len = 32'h0;
	logic [31:0]    trk_left = 32'h0;
	logic [23:0]    trk_max = pktdfr_pkg::MAX_LEN_RESET;
	logic [7:0]     tail_pat [3] = '{pktdfr_pkg::TAIL_B0, pktdfr_pkg::TAIL_B1,
		pktdfr_pkg::TAIL_B2};

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_result(input pktdfr_pkg::kind_t k, input logic [7:0] b);
		pktdfr_pkg::result_t r;
		r.kind           = k;
		r.payload_byte   = b;
		r.packet_index   = trk_index;
		r.packet_type    = trk_type;
		r.payload_length = trk_len;
		expected_results.push_back(r);
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		case (trk_phase)
			READ_INDEX: begin
				trk_index[8*trk_cnt +: 8] = b;
				if (trk_cnt == 2'd3) begin
					trk_cnt = 2'd0;
					trk_phase = READ_TYPE;
				end else begin
					trk_cnt++;
				end
			end
			READ_TYPE: begin
				trk_type[8*trk_cnt[0] +: 8] = b;
				if (trk_cnt >= 2'd1) begin
					trk_cnt = 2'd0;
					trk_phase = READ_LENGTH;
				end else begin
					trk_cnt++;
				end
			end
			READ_LENGTH: begin
				trk_len[8*trk_cnt +: 8] = b;
				if (trk_cnt != 2'd3) begin
					trk_cnt++;
				end else begin
					trk_cnt = 2'd0;
					if (trk_len > {8'h00, trk_max}) begin
						trk_phase = SEEK_HEADER;
						trk_recent = 16'h0;
						push_result(pktdfr_pkg::KIND_TOO_LONG, 8'h00);
					end else begin
						trk_left = trk_len;
						trk_phase = (trk_len == 32'h0) ? CHECK_TAIL : PASS_PAYLOAD;
					end
				end
			end
			PASS_PAYLOAD: begin
				push_result(pktdfr_pkg::KIND_PAYLOAD, b);
				trk_left--;
				if (trk_left == 32'h0) begin
					trk_cnt = 2'd0;
					trk_phase = CHECK_TAIL;
				end
			end
			CHECK_TAIL: begin
				if (trk_cnt > 2'd2 || b != tail_pat[trk_cnt]) begin
					// bad byte becomes the newest hunt byte
					trk_phase = SEEK_HEADER;
					trk_cnt = 2'd0;
					trk_recent = {8'h00, b};
					push_result(pktdfr_pkg::KIND_BAD_TAIL, 8'h00);
				end else if (trk_cnt == 2'd2) begin
					trk_phase = SEEK_HEADER;
					trk_cnt = 2'd0;
					trk_recent = 16'h0;
					push_result(pktdfr_pkg::KIND_ACCEPT, 8'h00);
				end else begin
					trk_cnt++;
				end
			end
			default: begin
				if (trk_recent == {pktdfr_pkg::HDR_B0, pktdfr_pkg::HDR_B1} &&
				    b == pktdfr_pkg::HDR_B2) begin
					trk_phase = READ_INDEX;
					trk_cnt = 2'd0;
					trk_recent = 16'h0;
					trk_index = 32'h0;
					trk_type = 16'h0;
					trk_len = 32'h0;
					trk_left = 32'h0;
				end else begin
					trk_phase = SEEK_HEADER;
					trk_recent = {trk_recent[7:0], b};
				end
			end
		endcase
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
		end else begin
			if (in_valid && !in_stall)
				deframe_byte(in_byte);
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_byte <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin : receiver
		pktdfr_pkg::result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected: kind %0d", kind);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (kind !== want.kind) begin
						$error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
						error_count++;
					end
					if (payload_byte !== want.payload_byte) begin
						$error("payload_byte mismatch: expected %0h, actual %0h",
							want.payload_byte, payload_byte);
						error_count++;
					end
					if (packet_index !== want.packet_index) begin
						$error("packet_index mismatch: expected %0h, actual %0h",
							want.packet_index, packet_index);
						error_count++;
					end
					if (packet_type !== want.packet_type) begin
						$error("packet_type mismatch: expected %0h, actual %0h",
							want.packet_type, packet_type);
						error_count++;
					end
					if (payload_length !== want.payload_length) begin
						$error("payload_length mismatch: expected %0h, actual %0h",
							want.payload_length, payload_length);
						error_count++;
					end
				end
			end
			// one long hold-off so the output fills and the input backs up
			if (start_long_hold && !long_hold_done) begin
				long_hold_done <= 1'b1;
				hold_left <= 400;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_made++;
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		// hunt and field bytes leave nothing to wait for
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_write(input logic [pktdfr_pkg::PADDR_W-1:0] addr,
		input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == pktdfr_pkg::REG_MAX_LEN)
			trk_max = data[23:0];
	endtask

	task automatic gen_packet(input logic [23:0] lim);
		int          n_noise;
		int          style;
		int          plen;
		logic [31:0] idx;
		logic [31:0] len;
		logic [15:0] typ;
		logic [7:0]  b;
		n_noise = $urandom_range(0, 3);
		for (int i = 0; i < n_noise; i++) begin
			case ($urandom_range(0, 3))
				0:       b = pktdfr_pkg::HDR_B0;
				1:       b = pktdfr_pkg::HDR_B1;
				2:       b = pktdfr_pkg::HDR_B2;
				default: b = 8'($urandom);
			endcase
			queue_byte(b);
		end
		idx = $urandom;
		typ = 16'($urandom);
		style = $urandom_range(0, 99);
		if (style < 12) begin
			if ($urandom_range(0, 1))
				len = {8'h00, lim} + 32'd1 + $urandom_range(0, 255);
			else
				len = $urandom | 32'h0100_0000;
		end else if (style < 20 && lim <= 24'd8) begin
			len = {8'h00, lim};
		end else begin
			len = $urandom_range(0, (lim < 24'd6) ? lim : 6);
		end
		queue_byte(pktdfr_pkg::HDR_B0);
		queue_byte(pktdfr_pkg::HDR_B1);
		// corrupted header: the rest of the packet is only hunted over
		queue_byte(($urandom_range(0, 99) < 8) ? 8'($urandom) : pktdfr_pkg::HDR_B2);
		for (int i = 0; i < 4; i++) queue_byte(idx[8*i +: 8]);
		for (int i = 0; i < 2; i++) queue_byte(typ[8*i +: 8]);
		for (int i = 0; i < 4; i++) queue_byte(len[8*i +: 8]);
		if (len > {8'h00, lim})
			return;
		plen = len;
		if (len > 1 && $urandom_range(0, 99) < 10) begin
			// truncated in the payload, next packet gets swallowed
			plen = $urandom_range(0, len - 1);
			for (int i = 0; i < plen; i++) queue_byte(8'($urandom));
			return;
		end
		for (int i = 0; i < plen; i++) queue_byte(8'($urandom));
		if ($urandom_range(0, 99) < 15) begin
			style = $urandom_range(0, 2);
			for (int i = 0; i < 3; i++) begin
				if (i == style)
					queue_byte($urandom_range(0, 3) == 0 ? pktdfr_pkg::HDR_B0 : 8'($urandom));
				else
					queue_byte(tail_pat[i]);
			end
		end else begin
			for (int i = 0; i < 3; i++) queue_byte(tail_pat[i]);
		end
	endtask

	initial begin
		logic [7:0]  directed_bytes [] = '{
			// near misses on the header
			8'hDD, 8'hAA, 8'hBB,
			// length 65536 over the reset maximum
			8'hDD, 8'hBB, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
			8'h00, 8'h00, 8'h01, 8'h00,
			// zero length, tail broken by DD which starts the next header
			8'hDD, 8'hBB, 8'hAA, 8'h78, 8'h56, 8'h34, 8'h12, 8'h34, 8'h12,
			8'h00, 8'h00, 8'h00, 8'h00, 8'hEE, 8'hDD,
			// good packet, extreme field values
			8'hBB, 8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
			8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hEE, 8'hBB, 8'hAA
		};
		logic [23:0] phase_max [6] = '{24'd4, 24'd0, 24'hFFFFFF, 24'd9, 24'd0, 24'd65535};
		logic [23:0] lim;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i]) queue_byte(directed_bytes[i]);

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			send_idle_pct <= (p < 2) ? 20 : (p < 4) ? 70 : 0;
			recv_idle_pct <= (p < 2) ? 70 : (p < 4) ? 20 : 0;
			lim = (p == 4) ? 24'($urandom_range(0, 12)) : phase_max[p];
			apb_write(pktdfr_pkg::REG_MAX_LEN, {8'h00, lim});
			bytes_made = 0;
			while (bytes_made < PHASE_BYTES) gen_packet(lim);
			if (p == 4) begin
				@(posedge clk);
				start_long_hold <= 1'b1;
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
